// ===== src/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the torn row detector: register map, reset
// values, configuration record and the job record passed front to back.
// ----------------------------------------------------------------------------
package trd_pkg;

    // Register map
    localparam int CFG_NUM    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCHES_REQUIRED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_START_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_END_OFFSET   = 3'd7;

    // Register reset values
    localparam logic [12:0] RST_FRAME_WIDTH       = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT      = 13'd480;
    localparam logic [6:0]  RST_WINDOW_LENGTH     = 7'd8;
    localparam logic [7:0]  RST_CHANNEL_THRESHOLD = 8'd5;
    localparam logic [11:0] RST_MATCHES_REQUIRED  = 12'd11;
    localparam logic [6:0]  RST_STEP_SIZE         = 7'd1;
    localparam logic [11:0] RST_SCAN_START_OFFSET = 12'd0;
    localparam logic [11:0] RST_SCAN_END_OFFSET   = 12'd0;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_WINDOW = 64;

    // Row index width covering the largest supported height
    localparam int ROW_W_MAX  = 13;
    localparam int TEAR_ROW_W = 12;

    localparam logic [11:0] HITS_MAX = 12'hFFF;

    // Job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [6:0]  window_length;
        logic [7:0]  channel_threshold;
        logic [11:0] matches_required;
        logic [6:0]  step_size;
        logic [11:0] scan_start_offset;
        logic [11:0] scan_end_offset;
    } t_cfg;

    typedef struct packed {
        logic                 new_frame;
        logic                 new_row;
        logic                 counts;
        logic                 at_start;
        logic                 last;
        logic [ROW_W_MAX-1:0] row;
    } t_job;

endpackage

// ===== src/trd_pix_if.sv =====
// ----------------------------------------------------------------------------
// trd_pix_if
// Pixel channel: new and displayed pixel plus first-of-frame mark.
// ----------------------------------------------------------------------------
interface trd_pix_if;
    logic       valid;
    logic       ready;
    logic       first_of_frame;
    logic [7:0] new_blue;
    logic [7:0] new_green;
    logic [7:0] new_red;
    logic [7:0] old_blue;
    logic [7:0] old_green;
    logic [7:0] old_red;

    modport source (
        output valid, first_of_frame, new_blue, new_green, new_red,
               old_blue, old_green, old_red,
        input  ready
    );
    modport sink (
        input  valid, first_of_frame, new_blue, new_green, new_red,
               old_blue, old_green, old_red,
        output ready
    );
endinterface

// ===== src/trd_res_if.sv =====
// ----------------------------------------------------------------------------
// trd_res_if
// Result channel: one tear report per frame.
// ----------------------------------------------------------------------------
interface trd_res_if;
    logic        valid;
    logic        ready;
    logic        tear_found;
    logic [11:0] tear_row;

    modport source (output valid, tear_found, tear_row, input ready);
    modport sink   (input valid, tear_found, tear_row, output ready);
endinterface

// ===== src/trd_front.sv =====
// ----------------------------------------------------------------------------
// trd_front
// Accepts pixels, tracks column and row, keeps per-row prefix sums of the
// channel differences in a window memory and classifies each window.
// ----------------------------------------------------------------------------
module trd_front #(
    parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = trd_pkg::DEF_MAX_WINDOW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trd_pkg::t_cfg i_cfg,
    input  logic          i_cfg_wr,
    trd_pix_if.sink       i_pix,
    output trd_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import trd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CW1   = CW + 1;
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int RW1   = RW + 1;
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int PW    = CW + 10;
    localparam int WLW   = $clog2(MAX_WINDOW + 1);
    localparam int THW   = WLW + 8;
    localparam int FCW   = $clog2(CW1 + 2);

    // Effective settings
    logic [CW1-1:0] w;
    logic [RW1-1:0] h;
    logic [RW1-1:0] h_m1;
    logic [WLW-1:0] wl;
    logic [THW-1:0] thr;
    logic [6:0]     step;
    logic [RW1-1:0] end_row;
    logic [RW1-1:0] start_row;

    always_comb begin
        if (i_cfg.frame_width == 13'd0) begin
            w = CW1'(1);
        end else if (32'(i_cfg.frame_width) > 32'(MAX_WIDTH)) begin
            w = CW1'(MAX_WIDTH);
        end else begin
            w = CW1'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == 13'd0) begin
            h = RW1'(1);
        end else if (32'(i_cfg.frame_height) > 32'(MAX_HEIGHT)) begin
            h = RW1'(MAX_HEIGHT);
        end else begin
            h = RW1'(i_cfg.frame_height);
        end
        h_m1 = h - RW1'(1);
        if (32'(i_cfg.window_length) > 32'(MAX_WINDOW)) begin
            wl = WLW'(MAX_WINDOW);
        end else begin
            wl = WLW'(i_cfg.window_length);
        end
        thr  = THW'(wl) * THW'(i_cfg.channel_threshold);
        step = (i_cfg.step_size == 7'd0) ? 7'd1 : i_cfg.step_size;
        if (32'(i_cfg.scan_end_offset) >= 32'(h)) begin
            end_row = h_m1;
        end else begin
            end_row = RW1'(32'(h_m1) - 32'(i_cfg.scan_end_offset));
        end
        if (32'(i_cfg.scan_start_offset) > 32'(end_row)) begin
            start_row = end_row;
        end else begin
            start_row = RW1'(i_cfg.scan_start_offset);
        end
    end

    // Position and window phase state
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [6:0]    r_phase, n_phase;
    logic signed [PW-1:0] r_psum [3];

    // Phase recompute after a register write
    logic [FCW-1:0] r_fix_cnt;
    logic [CW1-1:0] r_fix_q;
    logic [6:0]     r_fix_rem;
    logic [CW1-1:0] fix_q;
    logic [7:0]     fix_sh;
    logic [7:0]     fix_nx;
    logic           fix_busy;

    // Stage A
    logic                 r_a_valid;
    logic signed [PW-1:0] r_a_p [3];
    logic [3*PW-1:0]      r_rdata;
    logic                 r_a_zero;
    logic                 r_a_eval;
    logic                 r_a_row_in;
    logic                 r_a_at_start;
    logic                 r_a_new_frame;
    logic                 r_a_new_row;
    logic                 r_a_last;
    logic [RW-1:0]        r_a_row;

    logic [3*PW-1:0] r_mem [DEPTH];

    logic                 accept;
    logic                 push;
    logic [CW-1:0]        cur_c;
    logic [RW-1:0]        cur_r;
    logic [CW1-1:0]       c1;
    logic [6:0]           cur_phase;
    logic                 eval;
    logic                 zero_base;
    logic                 last_col;
    logic                 last_row;
    logic [AW-1:0]        wa;
    logic [AW-1:0]        ra;
    logic [7:0]           new_ch [3];
    logic [7:0]           old_ch [3];
    logic signed [8:0]    d_ch [3];
    logic signed [PW-1:0] p_new [3];
    logic [3*PW-1:0]      p_pack;
    logic signed [PW-1:0] base [3];
    logic signed [PW-1:0] s_ch [3];
    logic [PW-1:0]        a_ch [3];
    logic                 hit;

    assign fix_busy    = (r_fix_cnt != '0);
    assign push        = r_a_valid && i_job_ready;
    assign i_pix.ready = !fix_busy && !i_cfg_wr && (!r_a_valid || i_job_ready);
    assign accept      = i_pix.valid && i_pix.ready;

    // Classify the incoming pixel
    always_comb begin
        new_ch[0] = i_pix.new_blue;
        new_ch[1] = i_pix.new_green;
        new_ch[2] = i_pix.new_red;
        old_ch[0] = i_pix.old_blue;
        old_ch[1] = i_pix.old_green;
        old_ch[2] = i_pix.old_red;

        cur_c     = i_pix.first_of_frame ? '0 : r_col;
        cur_r     = i_pix.first_of_frame ? '0 : r_row;
        c1        = CW1'(cur_c) + CW1'(1);
        cur_phase = (cur_c == '0) ? 7'd0 : r_phase;
        eval      = (wl != '0) && (32'(c1) >= 32'(wl)) && (c1 < w) && (cur_phase == 7'd0);
        zero_base = (32'(c1) == 32'(wl));
        last_col  = (c1 >= w);
        last_row  = (RW1'(cur_r) + RW1'(1) >= h);
        wa        = AW'(32'(cur_c));
        ra        = AW'(32'(cur_c) - 32'(wl));

        for (int ch = 0; ch < 3; ch++) begin
            d_ch[ch]  = $signed({1'b0, new_ch[ch]}) - $signed({1'b0, old_ch[ch]});
            p_new[ch] = ((cur_c == '0) ? PW'(0) : r_psum[ch]) + PW'(d_ch[ch]);
        end
        p_pack = {p_new[2], p_new[1], p_new[0]};

        // Advance column, row and window phase
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : cur_r + RW'(1);
        end else begin
            n_col = CW'(c1);
            n_row = cur_r;
        end
        if (32'(c1) + 32'd1 == 32'(wl)) begin
            n_phase = 7'd0;
        end else if (cur_phase >= step - 7'd1) begin
            n_phase = 7'd0;
        end else begin
            n_phase = cur_phase + 7'd1;
        end
    end

    // Phase remainder: one restoring step per cycle
    always_comb begin
        fix_q  = CW1'(32'(r_col) + 32'd1 - 32'(wl));
        fix_sh = {r_fix_rem, r_fix_q[CW1-1]};
        fix_nx = (fix_sh >= {1'b0, step}) ? fix_sh - {1'b0, step} : fix_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_phase   <= 7'd0;
            r_fix_cnt <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_fix_cnt <= FCW'(CW1 + 1);
            end else if (fix_busy) begin
                r_fix_cnt <= r_fix_cnt - FCW'(1);
                if (r_fix_cnt == FCW'(CW1 + 1)) begin
                    r_fix_q   <= fix_q;
                    r_fix_rem <= 7'd0;
                end else begin
                    r_fix_q   <= r_fix_q << 1;
                    r_fix_rem <= fix_nx[6:0];
                    if (r_fix_cnt == FCW'(1)) begin
                        r_phase <= fix_nx[6:0];
                    end
                end
            end
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_phase <= n_phase;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (push) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Window memory and stage A payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wa]     <= p_pack;
            r_rdata       <= r_mem[ra];
            r_psum        <= p_new;
            r_a_p         <= p_new;
            r_a_zero      <= zero_base;
            r_a_eval      <= eval;
            r_a_row_in    <= (RW1'(cur_r) >= start_row) && (RW1'(cur_r) < end_row);
            r_a_at_start  <= (RW1'(cur_r) == start_row);
            r_a_new_frame <= (cur_c == '0) && (cur_r == '0);
            r_a_new_row   <= (cur_c == '0);
            r_a_last      <= last_col && last_row;
            r_a_row       <= cur_r;
        end
    end

    // Window sums and threshold test
    always_comb begin
        hit = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            base[ch] = r_a_zero ? PW'(0) : $signed(r_rdata[ch*PW +: PW]);
            s_ch[ch] = r_a_p[ch] - base[ch];
            a_ch[ch] = s_ch[ch][PW-1] ? PW'(-s_ch[ch]) : PW'(s_ch[ch]);
            if (a_ch[ch] > PW'(thr)) begin
                hit = 1'b1;
            end
        end
        o_job.new_frame = r_a_new_frame;
        o_job.new_row   = r_a_new_row;
        o_job.counts    = r_a_eval && hit && r_a_row_in;
        o_job.at_start  = r_a_at_start;
        o_job.last      = r_a_last;
        o_job.row       = ROW_W_MAX'(r_a_row);
    end

    assign o_job_valid = r_a_valid;

endmodule

// ===== src/trd_fifo.sv =====
// ----------------------------------------------------------------------------
// trd_fifo
// Short job queue between the classifying front and the counting back.
// ----------------------------------------------------------------------------
module trd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trd_pkg::t_job i_job,
    input  logic          i_valid,
    output logic          o_ready,
    output trd_pkg::t_job o_job,
    output logic          o_valid,
    input  logic          i_ready
);
    import trd_pkg::*;

    t_job                   r_ent [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   wr_en;
    logic                   rd_en;

    assign o_ready = (r_cnt != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_ent[r_rd];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + QUEUE_PTR_W'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + QUEUE_PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + QUEUE_CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - QUEUE_CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ent[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/trd_back.sv =====
// ----------------------------------------------------------------------------
// trd_back
// Counts differing windows per row, latches the first changed row and
// issues the per-frame tear report through an output register.
// ----------------------------------------------------------------------------
module trd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [11:0]   i_matches_required,
    input  trd_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    trd_res_if.source     o_res
);
    import trd_pkg::*;

    logic [11:0]          r_hits, n_hits;
    logic                 r_done, n_done;
    logic [ROW_W_MAX-1:0] r_found, n_found;
    logic                 r_o_valid;
    logic                 r_o_found;
    logic [11:0]          r_o_row;
    logic [11:0]          need;
    logic                 pop;

    assign need        = (i_matches_required == 12'd0) ? 12'd1 : i_matches_required;
    assign o_job_ready = !i_job.last || !r_o_valid || o_res.ready;
    assign pop         = i_job_valid && o_job_ready;

    // Update search state for one window
    always_comb begin
        n_hits  = r_hits;
        n_done  = r_done;
        n_found = r_found;
        if (i_job.new_frame) begin
            n_done  = 1'b0;
            n_found = '0;
        end
        if (i_job.new_row) begin
            n_hits = 12'd0;
        end
        if (i_job.counts && !n_done) begin
            if (n_hits != HITS_MAX) begin
                n_hits = n_hits + 12'd1;
            end
            if (n_hits >= need) begin
                n_done  = 1'b1;
                n_found = i_job.at_start ? '0 : i_job.row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits    <= 12'd0;
            r_done    <= 1'b0;
            r_found   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_hits  <= n_hits;
                r_done  <= n_done;
                r_found <= n_found;
            end
            if (pop && i_job.last) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold the report until taken
    always_ff @(posedge i_clk) begin
        if (pop && i_job.last) begin
            r_o_found <= (n_found != '0);
            r_o_row   <= n_found[TEAR_ROW_W-1:0];
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.tear_found = r_o_found;
    assign o_res.tear_row   = r_o_row;

endmodule

// ===== src/torn_row_detector.sv =====
// ----------------------------------------------------------------------------
// torn_row_detector
// Finds the first scan row where a captured frame differs from the frame on
// display, using sliding window sums of the channel differences.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while not held off; the frame's
// report enters the output register after its last pixel passes stage A and
// the job queue. The pixel input keeps flowing while a report waits, until
// the next frame's last job stalls in the back end and the job queue fills.
// Window sums come from per-row prefix sums held in a window memory with one
// write and one read port. After each register write the input holds off
// while a one-bit-per-cycle remainder unit recomputes the window phase.
module torn_row_detector #(
    parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = trd_pkg::DEF_MAX_WINDOW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [trd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [trd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [trd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    trd_pix_if.sink                          i_pix,
    trd_res_if.source                        o_res
);
    import trd_pkg::*;

    t_cfg                 r_cfg;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_job                 front_job;
    logic                 front_valid;
    logic                 front_ready;
    t_job                 back_job;
    logic                 back_valid;
    logic                 back_ready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width       <= RST_FRAME_WIDTH;
            r_cfg.frame_height      <= RST_FRAME_HEIGHT;
            r_cfg.window_length     <= RST_WINDOW_LENGTH;
            r_cfg.channel_threshold <= RST_CHANNEL_THRESHOLD;
            r_cfg.matches_required  <= RST_MATCHES_REQUIRED;
            r_cfg.step_size         <= RST_STEP_SIZE;
            r_cfg.scan_start_offset <= RST_SCAN_START_OFFSET;
            r_cfg.scan_end_offset   <= RST_SCAN_END_OFFSET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:       r_cfg.frame_width       <= pwdata[12:0];
                REG_FRAME_HEIGHT:      r_cfg.frame_height      <= pwdata[12:0];
                REG_WINDOW_LENGTH:     r_cfg.window_length     <= pwdata[6:0];
                REG_CHANNEL_THRESHOLD: r_cfg.channel_threshold <= pwdata[7:0];
                REG_MATCHES_REQUIRED:  r_cfg.matches_required  <= pwdata[11:0];
                REG_STEP_SIZE:         r_cfg.step_size         <= pwdata[6:0];
                REG_SCAN_START_OFFSET: r_cfg.scan_start_offset <= pwdata[11:0];
                REG_SCAN_END_OFFSET:   r_cfg.scan_end_offset   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:       prdata = APB_DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT:      prdata = APB_DATA_W'(r_cfg.frame_height);
            REG_WINDOW_LENGTH:     prdata = APB_DATA_W'(r_cfg.window_length);
            REG_CHANNEL_THRESHOLD: prdata = APB_DATA_W'(r_cfg.channel_threshold);
            REG_MATCHES_REQUIRED:  prdata = APB_DATA_W'(r_cfg.matches_required);
            REG_STEP_SIZE:         prdata = APB_DATA_W'(r_cfg.step_size);
            REG_SCAN_START_OFFSET: prdata = APB_DATA_W'(r_cfg.scan_start_offset);
            REG_SCAN_END_OFFSET:   prdata = APB_DATA_W'(r_cfg.scan_end_offset);
            default:               prdata = '0;
        endcase
    end

    trd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (cfg_wr),
        .i_pix       (i_pix),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    trd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_job   (back_job),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    trd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_matches_required (r_cfg.matches_required),
        .i_job              (back_job),
        .i_job_valid        (back_valid),
        .o_job_ready        (back_ready),
        .o_res              (o_res)
    );

endmodule
